// ===== rtl/sha_pkg.sv =====
// Shared types, constants and functions of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sha_pkg;

   localparam int BLOCK_WORDS = 16;
   localparam int DIGEST_WORDS = 8;
   localparam int ROUNDS = 64;
   localparam int COUNT_W = 61;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_H [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // byte write into the block buffer
   typedef struct packed {
      logic       en;
      logic [5:0] pos;
      logic [7:0] data;
   } sha_byte_wr_type;

   typedef struct packed {
      logic start_comp;
      logic start_out;
   } sha_core_cmd_type;

   typedef struct packed {
      logic comp_done;
      logic out_done;
   } sha_core_status_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/sha_msg_buf.sv =====
// Block buffer: byte assembler in front of a 16-word synchronous memory.
`timescale 1ns / 1ps

module sha_msg_buf
   import sha_pkg::*;
(
   input  logic            clock,
   input  sha_byte_wr_type wr,
   input  logic            rd_en,
   input  logic [3:0]      rd_addr,
   output logic [31:0]     rd_data
);

   logic [31:0] mem [BLOCK_WORDS];
   logic [31:0] word_ff;
   logic [31:0] word_in;
   logic [31:0] rd_data_ff;

   // bytes of a word arrive in order, most significant lane first
   always_comb begin
      word_in = word_ff;
      case (wr.pos[1:0])
         2'd0:    word_in = {wr.data, word_ff[23:0]};
         2'd1:    word_in = {word_ff[31:24], wr.data, word_ff[15:0]};
         2'd2:    word_in = {word_ff[31:16], wr.data, word_ff[7:0]};
         2'd3:    word_in = {word_ff[31:8], wr.data};
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         word_ff <= word_in;
         if (wr.pos[1:0] == 2'd3) begin
            mem[wr.pos[5:2]] <= word_in;
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sha_core.sv =====
// Compression core: round datapath, message schedule and chain value memory.
`timescale 1ns / 1ps

module sha_core
   import sha_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  sha_core_cmd_type    cmd,
   output sha_core_status_type status,
   output logic                msg_rd_en,
   output logic [3:0]          msg_rd_addr,
   input  logic [31:0]         msg_rd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);

   localparam logic [2:0] P_IDLE  = 3'd0;
   localparam logic [2:0] P_LOAD  = 3'd1;
   localparam logic [2:0] P_ROUND = 3'd2;
   localparam logic [2:0] P_ADD   = 3'd3;
   localparam logic [2:0] P_ORD   = 3'd4;
   localparam logic [2:0] P_OWAIT = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        init_ff, init_in;
   logic [31:0] v_ff [DIGEST_WORDS];
   logic [31:0] v_in [DIGEST_WORDS];
   logic [31:0] w_ff [BLOCK_WORDS];
   logic [31:0] w_in [BLOCK_WORDS];

   logic [31:0] chain_mem [DIGEST_WORDS];
   logic [31:0] chain_rd_ff;
   logic        chain_re, chain_we;
   logic [2:0]  chain_raddr;
   logic [2:0]  prev_idx;
   logic [31:0] base;
   logic [31:0] w_t, t1, t2, ch, maj;

   // entry read in the previous cycle; chain reads as initial values until written back after reset or digest output
   assign prev_idx = cnt_ff[2:0] - 3'd1;
   assign base = init_ff ? START_H[prev_idx] : chain_rd_ff;

   assign w_t = (cnt_ff < 6'd16) ? msg_rd_data :
                w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + ROUND_K[cnt_ff] + w_t;
   assign t2  = big_sigma0(v_ff[0]) + maj;

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      oidx_in     = oidx_ff;
      init_in     = init_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      chain_re    = 1'b0;
      chain_raddr = cnt_ff[2:0];
      chain_we    = 1'b0;
      msg_rd_en   = 1'b0;
      msg_rd_addr = 4'd0;
      status      = '0;
      case (phase_ff)
         P_IDLE: begin
            cnt_in = 6'd0;
            if (cmd.start_comp) begin
               phase_in = P_LOAD;
            end else if (cmd.start_out) begin
               oidx_in  = 3'd0;
               phase_in = P_ORD;
            end
         end
         P_LOAD: begin
            chain_re = (cnt_ff < 6'd8);
            if (cnt_ff != 6'd0) begin
               for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                  v_in[i] = v_ff[i + 1];
               end
               v_in[DIGEST_WORDS - 1] = base;
            end
            if (cnt_ff == 6'd8) begin
               msg_rd_en = 1'b1;
               cnt_in    = 6'd0;
               phase_in  = P_ROUND;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         P_ROUND: begin
            // prefetch the next block word
            msg_rd_en   = (cnt_ff < 6'd15);
            msg_rd_addr = cnt_ff[3:0] + 4'd1;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[BLOCK_WORDS - 1] = w_t;
            v_in[0] = t1 + t2;
            v_in[1] = v_ff[0];
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3] + t1;
            v_in[5] = v_ff[4];
            v_in[6] = v_ff[5];
            v_in[7] = v_ff[6];
            if (cnt_ff == 6'(ROUNDS - 1)) begin
               cnt_in   = 6'd0;
               phase_in = P_ADD;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         P_ADD: begin
            chain_re = (cnt_ff < 6'd8);
            if (cnt_ff != 6'd0) begin
               chain_we = 1'b1;
               for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                  v_in[i] = v_ff[i + 1];
               end
            end
            if (cnt_ff == 6'd8) begin
               init_in          = 1'b0;
               status.comp_done = 1'b1;
               // go straight to the digest when the last block is done
               if (cmd.start_out) begin
                  oidx_in  = 3'd0;
                  phase_in = P_ORD;
               end else begin
                  phase_in = P_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         P_ORD: begin
            chain_re    = 1'b1;
            chain_raddr = oidx_ff;
            phase_in    = P_OWAIT;
         end
         P_OWAIT: begin
            if (!rsp_stall) begin
               if (oidx_ff == 3'd7) begin
                  init_in         = 1'b1;
                  status.out_done = 1'b1;
                  phase_in        = P_IDLE;
               end else begin
                  oidx_in  = oidx_ff + 3'd1;
                  phase_in = P_ORD;
               end
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[prev_idx] <= base + v_ff[0];
      end
      if (chain_re) begin
         chain_rd_ff <= chain_mem[chain_raddr];
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= 6'd0;
         oidx_ff  <= 3'd0;
         init_ff  <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         oidx_ff  <= oidx_in;
         init_ff  <= init_in;
      end
   end

   // result payload comes straight from the chain read register, held while no read is issued
   assign rsp_valid       = (phase_ff == P_OWAIT);
   assign rsp_digest_word = chain_rd_ff;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 hasher over a byte stream: request control, padding and top level.
//
// Request channel: req_valid/req_stall with req_message_byte, req_has_byte and
// req_end_of_message. A request with has_byte set adds one message byte; one
// with end_of_message set closes the message (after its byte, if any).
// Result channel: rsp_valid/rsp_stall carries eight digest words per message,
// rsp_word_index 0 first, rsp_last_word on index 7.
// Throughput: one byte request per cycle while a block fills. The request that
// completes a 64-byte block is followed by stalled compression (8 chain
// reads, 64 rounds, 8 chain reads with write-backs, one word at a time).
// End of message: padding and length are written one byte per cycle up to the
// end of the block (plus one more compression and up to 56 zero bytes when
// the length does not fit), then compression, then the eight words, each
// read from the chain memory, then presented.
// A stalled result word holds; no requests are taken until the last word goes.
// Reset returns the chain value to the initial hash values and clears the
// byte count; the block buffer needs no clearing.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COMP = 3'd1;
   localparam logic [2:0] S_PAD  = 3'd2;
   localparam logic [2:0] S_ZERO = 3'd3;
   localparam logic [2:0] S_LEN  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         ret_ff, ret_in;
   logic [5:0]         fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               wrap_ff, wrap_in;
   logic               req_accept;
   logic [63:0]        len_bits;
   logic [63:0]        len_shift;

   sha_byte_wr_type     wr;
   sha_core_cmd_type    cmd;
   sha_core_status_type status;
   logic                msg_rd_en;
   logic [3:0]          msg_rd_addr;
   logic [31:0]         msg_rd_data;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // length bytes go out big-endian, position 56 carries the top byte
   assign len_bits  = {count_ff, 3'b000};
   assign len_shift = len_bits >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      wrap_in  = wrap_ff;
      wr       = '0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_has_byte) begin
                  wr       = '{en: 1'b1, pos: fill_ff, data: req_message_byte};
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_has_byte && fill_ff == LAST_POS) begin
                  cmd.start_comp = 1'b1;
                  ret_in   = req_end_of_message ? S_PAD : S_IDLE;
                  state_in = S_COMP;
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_COMP: begin
            if (status.comp_done) begin
               fill_in  = 6'd0;
               state_in = ret_ff;
               if (ret_ff == S_OUT) begin
                  cmd.start_out = 1'b1;
                  count_in      = '0;
               end
            end
         end
         S_PAD: begin
            wr      = '{en: 1'b1, pos: fill_ff, data: PAD_BYTE};
            fill_in = fill_ff + 6'd1;
            // no room for the length after the pad byte: zero out this block first
            wrap_in = (fill_ff >= LEN_OFFSET) && (fill_ff != LAST_POS);
            if (fill_ff == LAST_POS) begin
               cmd.start_comp = 1'b1;
               ret_in   = S_ZERO;
               state_in = S_COMP;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (!wrap_ff && fill_ff == LEN_OFFSET) begin
               state_in = S_LEN;
            end else begin
               wr      = '{en: 1'b1, pos: fill_ff, data: 8'h00};
               fill_in = fill_ff + 6'd1;
               if (fill_ff == LAST_POS) begin
                  cmd.start_comp = 1'b1;
                  wrap_in  = 1'b0;
                  ret_in   = S_ZERO;
                  state_in = S_COMP;
               end
            end
         end
         S_LEN: begin
            wr      = '{en: 1'b1, pos: fill_ff, data: len_shift[7:0]};
            fill_in = fill_ff + 6'd1;
            if (fill_ff == LAST_POS) begin
               cmd.start_comp = 1'b1;
               ret_in   = S_OUT;
               state_in = S_COMP;
            end
         end
         S_OUT: begin
            if (status.out_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         fill_ff  <= 6'd0;
         count_ff <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         wrap_ff  <= wrap_in;
      end
   end

   sha_msg_buf u_msg_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (msg_rd_en),
      .rd_addr (msg_rd_addr),
      .rd_data (msg_rd_data)
   );

   sha_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .msg_rd_en       (msg_rd_en),
      .msg_rd_addr     (msg_rd_addr),
      .msg_rd_data     (msg_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ===== rtl/sha_checker.sv =====
// Port-level checker for the SHA-256 byte stream hasher, with its bind.
`timescale 1ns / 1ps

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index) && $stable(rsp_last_word))
      else $error("stalled result changed");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word_index");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while digest is going out");

   a_index_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_word |=> ##1 rsp_valid
         && (rsp_word_index == $past(rsp_word_index, 2) + 3'd1))
      else $error("digest word index did not advance by one");

   a_release_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_word |=> !req_stall && !rsp_valid)
      else $error("request channel not released after last digest word");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
